@@ rtl/srss_pkg.sv @@
// Package for the sparse row set store: sizes, command and status codes,
// and the sequencer state type. Depends on nothing.
`default_nettype none

package srss_pkg;

	// Default sizes of the store.
	localparam int ROWS_DEF         = 64;
	localparam int ROW_CAPACITY_DEF = 16;
	localparam int COL_BITS_DEF     = 16;

	// Field widths on the stream and configuration ports.
	localparam int CMD_W    = 2;
	localparam int ROW_W    = 6;
	localparam int COL_W    = 16;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 5;
	localparam int TOTAL_W  = 11;
	localparam int NROWS_W  = 7;

	// Reset value of the row limit register.
	localparam logic [NROWS_W-1:0] NUM_ROWS_RESET = 7'd64;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_ROW = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_BAD_POS = 3'd4;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_DECODE,
		ST_SCAN,
		ST_APPEND,
		ST_READ,
		ST_READ_WAIT,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/sparse_row_set_store_top.sv @@
// Sparse row set store: per-row column lists with duplicate-checked insert,
// positional read and clear. Depends on srss_pkg.
`default_nettype none

// One command is taken at a time, and the input side stays not ready until
// its result has been loaded into the output register. A rejected row goes
// straight from the input transfer to the result. Any other command except
// a clear reads the row length and decodes; the unused command and a read at
// or past the row's length then answer, a read fetches the stored entry and
// an insert appends. An insert with the duplicate check into a row that
// holds entries first scans the row one stored entry per cycle through
// the single read port of the entry memory and one shared comparator; a
// duplicate ends the scan early. The longest insert is a checked insert into
// a full row. A clear command walks the row length memory one row per cycle
// and answers at the end of its pass. The input side is ready again in the
// cycle after the load. After reset and after every write of the row limit
// register the same pass runs with the input side not ready; register writes
// are taken at any time. The result sits in an output register, so the next
// command may be accepted while a result still waits to be taken.
module sparse_row_set_store_top #(
	parameter int ROWS         = srss_pkg::ROWS_DEF,
	parameter int ROW_CAPACITY = srss_pkg::ROW_CAPACITY_DEF,
	parameter int COL_BITS     = srss_pkg::COL_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Row limit register write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data,   // num_rows
	// Command stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,    // row[5:0], col[21:6], check_duplicate[22],
	                                     // position[26:23], zero fill above
	input  wire logic [1:0]  s_tuser,    // cmd[1:0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,    // col_out[15:0], row_length[20:16],
	                                     // total_count[31:21]
	output logic [2:0]       m_tuser     // status[2:0]
);

	localparam int ENTRIES = ROWS * ROW_CAPACITY;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RIW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LW      = $clog2(ROW_CAPACITY + 1);
	localparam int TW      = $clog2(ENTRIES + 1);

	// Storage.
	logic [COL_BITS-1:0] entry_mem [ENTRIES];
	logic [LW-1:0]       row_len_mem [ROWS];

	// Sequencer and control registers.
	srss_pkg::state_t state_q, state_d;
	logic [RIW-1:0]                 clr_cnt_q;
	logic                           clr_reply_q;
	logic [TW-1:0]                  total_q;
	logic [srss_pkg::NROWS_W-1:0]   num_rows_q;
	logic                           out_valid_q;
	logic                           cmp_pend_q;
	logic [LW-1:0]                  iss_idx_q;

	// Latched command and working values.
	logic [srss_pkg::CMD_W-1:0]     cmd_q;
	logic [srss_pkg::ROW_W-1:0]     row_q;
	logic [COL_BITS-1:0]            col_q;
	logic                           chk_q;
	logic [srss_pkg::POS_W-1:0]     pos_q;
	logic [AW-1:0]                  base_q;
	logic [LW-1:0]                  len_q;
	logic [LW-1:0]                  rl_rd_q;
	logic [COL_BITS-1:0]            ent_rd_q;
	logic [srss_pkg::STATUS_W-1:0]  res_status_q;
	logic [COL_BITS-1:0]            res_col_q;
	logic [LW-1:0]                  res_len_q;

	// Output register.
	logic [srss_pkg::STATUS_W-1:0]  out_status_q;
	logic [srss_pkg::COL_W-1:0]     out_col_q;
	logic [srss_pkg::LEN_W-1:0]     out_len_q;
	logic [srss_pkg::TOTAL_W-1:0]   out_total_q;

	// Input field unpacking.
	logic [srss_pkg::CMD_W-1:0]     in_cmd;
	logic [srss_pkg::ROW_W-1:0]     in_row;
	logic [srss_pkg::COL_W-1:0]     in_col;
	logic                           in_chk;
	logic [srss_pkg::POS_W-1:0]     in_pos;

	assign in_cmd = s_tuser;
	assign in_row = s_tdata[5:0];
	assign in_col = s_tdata[21:6];
	assign in_chk = s_tdata[22];
	assign in_pos = s_tdata[26:23];

	// Handshake events.
	logic in_xfer, cfg_xfer, out_free;
	logic clr_start;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign in_xfer   = s_tvalid & s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign clr_start = in_xfer && (in_cmd == srss_pkg::CMD_CLEAR);

	// Effective row limit is the register saturated to the row count.
	logic [srss_pkg::NROWS_W-1:0] row_limit;
	logic                         in_row_ok;

	assign row_limit = (32'(num_rows_q) > ROWS) ? srss_pkg::NROWS_W'(ROWS) : num_rows_q;
	assign in_row_ok = {1'b0, in_row} < row_limit;

	// Row index, clear pass end and scan status.
	logic [RIW-1:0] row_idx;
	logic           clr_last;
	logic           issuing;
	logic           scan_hit;
	logic           row_full;

	assign row_idx  = RIW'(row_q);
	assign clr_last = 32'(clr_cnt_q) == ROWS - 1;
	assign issuing  = iss_idx_q < len_q;
	assign scan_hit = cmp_pend_q && (ent_rd_q == col_q);
	assign row_full = 32'(len_q) >= ROW_CAPACITY;

	// Memory control, set by the output decoder.
	logic           rl_we;
	logic [RIW-1:0] rl_waddr;
	logic [LW-1:0]  rl_wdata;
	logic           ent_we;
	logic [LW-1:0]  ent_off;
	logic           out_load;
	logic [AW-1:0]  ent_addr;

	assign ent_addr = AW'(32'(base_q) + 32'(ent_off));

	// Next state.
	always_comb begin
		state_d = state_q;
		if (cfg_xfer) begin
			state_d = srss_pkg::ST_CLEAR;
		end else begin
			case (state_q)
				srss_pkg::ST_CLEAR: begin
					if (clr_last) begin
						state_d = clr_reply_q ? srss_pkg::ST_RESULT : srss_pkg::ST_IDLE;
					end
				end
				srss_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (in_cmd == srss_pkg::CMD_CLEAR) begin
							state_d = srss_pkg::ST_CLEAR;
						end else if (!in_row_ok) begin
							state_d = srss_pkg::ST_RESULT;
						end else begin
							state_d = srss_pkg::ST_LEN;
						end
					end
				end
				srss_pkg::ST_LEN: begin
					state_d = srss_pkg::ST_DECODE;
				end
				srss_pkg::ST_DECODE: begin
					case (cmd_q)
						srss_pkg::CMD_INSERT: begin
							state_d = (chk_q && rl_rd_q != '0) ? srss_pkg::ST_SCAN
							                                   : srss_pkg::ST_APPEND;
						end
						srss_pkg::CMD_READ: begin
							state_d = (32'(pos_q) >= 32'(rl_rd_q)) ? srss_pkg::ST_RESULT
							                                       : srss_pkg::ST_READ;
						end
						default: begin
							state_d = srss_pkg::ST_RESULT;
						end
					endcase
				end
				srss_pkg::ST_SCAN: begin
					if (scan_hit) begin
						state_d = srss_pkg::ST_RESULT;
					end else if (!issuing && !cmp_pend_q) begin
						state_d = srss_pkg::ST_APPEND;
					end
				end
				srss_pkg::ST_APPEND: begin
					state_d = srss_pkg::ST_RESULT;
				end
				srss_pkg::ST_READ: begin
					state_d = srss_pkg::ST_READ_WAIT;
				end
				srss_pkg::ST_READ_WAIT: begin
					state_d = srss_pkg::ST_RESULT;
				end
				srss_pkg::ST_RESULT: begin
					if (out_free) begin
						state_d = srss_pkg::ST_IDLE;
					end
				end
				default: begin
					state_d = srss_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output decoder: handshake and memory controls.
	always_comb begin
		s_tready = 1'b0;
		rl_we    = 1'b0;
		rl_waddr = row_idx;
		rl_wdata = LW'(32'(len_q) + 1);
		ent_we   = 1'b0;
		ent_off  = LW'(pos_q);
		out_load = 1'b0;
		case (state_q)
			srss_pkg::ST_CLEAR: begin
				rl_we    = 1'b1;
				rl_waddr = clr_cnt_q;
				rl_wdata = '0;
			end
			srss_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			srss_pkg::ST_SCAN: begin
				ent_off = iss_idx_q;
			end
			srss_pkg::ST_APPEND: begin
				ent_off = len_q;
				rl_we   = !row_full;
				ent_we  = !row_full;
			end
			srss_pkg::ST_RESULT: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srss_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			total_q     <= '0;
			num_rows_q  <= srss_pkg::NUM_ROWS_RESET;
			out_valid_q <= 1'b0;
			cmp_pend_q  <= 1'b0;
			iss_idx_q   <= '0;
		end else begin
			state_q    <= state_d;
			cmp_pend_q <= (state_q == srss_pkg::ST_SCAN) && issuing && !scan_hit;

			// A register write or a clear command restarts the clear pass,
			// which otherwise steps one row per cycle.
			if (cfg_xfer || clr_start) begin
				clr_cnt_q <= '0;
			end else if (state_q == srss_pkg::ST_CLEAR && !clr_last) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end

			// A clear command answers at the end of its pass; a register
			// write empties the store without an answer.
			if (cfg_xfer) begin
				clr_reply_q <= 1'b0;
			end else if (clr_start) begin
				clr_reply_q <= 1'b1;
			end

			// Row limit register.
			if (cfg_xfer) begin
				num_rows_q <= cfg_data;
			end

			// Scan issue index.
			if (state_q == srss_pkg::ST_DECODE) begin
				iss_idx_q <= '0;
			end else if (state_q == srss_pkg::ST_SCAN && issuing) begin
				iss_idx_q <= iss_idx_q + 1'b1;
			end

			// Entry total.
			if (cfg_xfer || clr_start) begin
				total_q <= '0;
			end else if (state_q == srss_pkg::ST_APPEND && !row_full) begin
				total_q <= total_q + 1'b1;
			end

			// Output valid.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command latch and result values.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q        <= in_cmd;
			row_q        <= in_row;
			col_q        <= COL_BITS'(in_col);
			chk_q        <= in_chk;
			pos_q        <= in_pos;
			res_col_q    <= '0;
			res_len_q    <= '0;
			res_status_q <= (in_cmd != srss_pkg::CMD_CLEAR && in_cmd != srss_pkg::CMD_NONE
				&& !in_row_ok) ? srss_pkg::STAT_BAD_ROW : srss_pkg::STAT_OK;
		end
		if (state_q == srss_pkg::ST_LEN) begin
			base_q <= AW'(32'(row_idx) * ROW_CAPACITY);
		end
		if (state_q == srss_pkg::ST_DECODE) begin
			len_q     <= rl_rd_q;
			res_len_q <= rl_rd_q;
			if (cmd_q == srss_pkg::CMD_READ && 32'(pos_q) >= 32'(rl_rd_q)) begin
				res_status_q <= srss_pkg::STAT_BAD_POS;
			end
		end
		if (state_q == srss_pkg::ST_SCAN && scan_hit) begin
			res_status_q <= srss_pkg::STAT_DUP;
		end
		if (state_q == srss_pkg::ST_APPEND) begin
			if (row_full) begin
				res_status_q <= srss_pkg::STAT_FULL;
			end else begin
				res_len_q <= LW'(32'(len_q) + 1);
			end
		end
		if (state_q == srss_pkg::ST_READ_WAIT) begin
			res_col_q <= ent_rd_q;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_col_q    <= srss_pkg::COL_W'(res_col_q);
			out_len_q    <= srss_pkg::LEN_W'(res_len_q);
			out_total_q  <= srss_pkg::TOTAL_W'(total_q);
		end
	end

	// Row length memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (rl_we) begin
			row_len_mem[rl_waddr] <= rl_wdata;
		end
		rl_rd_q <= row_len_mem[row_idx];
	end

	// Entry memory: one port, write or registered read.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_addr] <= col_q;
		end
		ent_rd_q <= entry_mem[ent_addr];
	end

	// Result stream.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_total_q, out_len_q, out_col_q};
	assign m_tuser  = out_status_q;

	// The scan never issues past the row's length.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srss_pkg::ST_SCAN) |-> (iss_idx_q <= len_q))
		else $error("scan index beyond row length");

	// A successful append adds exactly one entry to the total.
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srss_pkg::ST_APPEND && !row_full && !cfg_xfer)
		|=> (total_q == TW'($past(total_q) + 1'b1)))
		else $error("entry total not advanced by one on append");

	// A duplicate is only found for an insert that asked for the check.
	a_dup_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srss_pkg::ST_SCAN && scan_hit)
		|-> (chk_q && cmd_q == srss_pkg::CMD_INSERT))
		else $error("duplicate found outside a checked insert");

	// A rejected row reports an empty length and no column.
	a_bad_row_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_status_q == srss_pkg::STAT_BAD_ROW)
		|-> (out_len_q == '0 && out_col_q == '0))
		else $error("bad row result carries row data");

endmodule

`default_nettype wire
